// ===== design/radix_integer_to_ascii_core_assert.svh =====
// Assertion macros shared by the radix-to-ASCII checker.
// No dependencies; include by bare file name.
`ifndef RADIX_INTEGER_TO_ASCII_CORE_ASSERT_SVH
`define RADIX_INTEGER_TO_ASCII_CORE_ASSERT_SVH

// same-cycle implication
`define RITA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rita assertion failed");

// next-cycle implication
`define RITA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rita assertion failed");

`endif

// ===== design/rita_pkg.sv =====
// Shared constants, types and the digit glyph function for the radix-to-ASCII core.
// No dependencies.
package rita_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_DIGITS_DEF = 32;
  localparam int RADIX_W        = 8;
  localparam int DIGIT_W        = 6;
  localparam int CHAR_W         = 7;
  localparam int DIV_STEP       = 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 8'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 8'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 8'd36;
  localparam logic [DIGIT_W-1:0] DIGIT_TOP   = 6'd35;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 6'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_LOW_A  = 7'h61;
  localparam logic [CHAR_W-1:0]  CHAR_NONE   = 7'h00;

  typedef struct packed {
    logic load;
    logic div_step;
    logic div_end;
    logic rd_first;
    logic rd_step;
    logic empty;
  } dp_cmd_t;

  typedef struct packed {
    logic radix_bad;
    logic quo_zero;
    logic cnt_full;
    logic rd_zero;
  } dp_sts_t;

  function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] dc;
    dc = (d > DIGIT_TOP) ? DIGIT_TOP : d;
    if (dc < DIGIT_TEN) begin
      return CHAR_ZERO + CHAR_W'(dc);
    end else begin
      return CHAR_LOW_A + CHAR_W'(dc - DIGIT_TEN);
    end
  endfunction

endpackage

// ===== design/radix_integer_to_ascii_core.sv =====
// Top level of the radix integer-to-ASCII converter.
// Depends on rita_pkg, rita_ctrl, rita_dp, rita_ram.
//
// Usage:
//   Input: in_value is taken at a rising edge with start high and busy low.
//   Config: cfg_radix (2 to 36 valid, 10 after reset) is written when cfg_valid
//     and cfg_ready are high; cfg_ready is high whenever busy and start are low.
//   Output: one ASCII digit per transfer, most significant first, on
//     out_char_code with out_strobe high for one cycle; out_is_last marks the
//     final digit. A radix outside 2..36 gives a single transfer with
//     out_is_empty and out_is_last set and a char code of 0.
//   Timing: each digit is computed by the eight-bit-per-cycle divider in the
//     datapath, which divides the whole value once per digit. After the last
//     division the characters are transferred one per cycle. busy stays high
//     until the final transfer is done, so one value is finished before the
//     next is taken. An invalid radix needs no division.
//   Reset: synchronous on rst_n low; clears the controller, output strobe and
//     restores the radix to 10. The digit RAM needs no clearing.
//   The receiver cannot stall; every transfer is taken as it is shown.
module radix_integer_to_ascii_core #(
  parameter int VALUE_BITS = rita_pkg::VALUE_BITS_DEF,
  parameter int MAX_DIGITS = rita_pkg::MAX_DIGITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [VALUE_BITS-1:0]        in_value,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rita_pkg::RADIX_W-1:0] cfg_radix,
  output logic                         out_strobe,
  output logic [rita_pkg::CHAR_W-1:0]  out_char_code,
  output logic                         out_is_last,
  output logic                         out_is_empty
);
  import rita_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // no radix write at the edge that takes a value
  assign cfg_ready = ~busy & ~start;

  rita_ctrl #(
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  rita_dp #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_value      (in_value),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_radix     (cfg_radix),
    .out_strobe    (out_strobe),
    .out_char_code (out_char_code),
    .out_is_last   (out_is_last),
    .out_is_empty  (out_is_empty)
  );

endmodule

// ===== design/rita_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rita_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/rita_ctrl.sv =====
// Controller FSM for the radix-to-ASCII core: sequences division passes and emission.
// Depends on rita_pkg.
module rita_ctrl #(
  parameter int VALUE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  rita_pkg::dp_sts_t sts,
  output rita_pkg::dp_cmd_t cmd,
  output logic              busy
);
  import rita_pkg::*;

  localparam int DIV_W  = ((VALUE_BITS + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
  localparam int GROUPS = DIV_W / DIV_STEP;
  localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIV   = 4'b0010,
    ST_EMIT  = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  state_t        state_r, state_nxt;
  logic [GW-1:0] grp_r, grp_nxt;
  logic          grp_last;

  assign grp_last = (grp_r == GW'(GROUPS - 1));

  always_comb begin
    state_nxt = state_r;
    grp_nxt   = grp_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (sts.radix_bad) begin
            cmd.empty = 1'b1;
            state_nxt = ST_DRAIN;
          end else begin
            cmd.load  = 1'b1;
            grp_nxt   = '0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (grp_last) begin
          cmd.div_end = 1'b1;
          grp_nxt     = '0;
          if (sts.quo_zero || sts.cnt_full) begin
            cmd.rd_first = 1'b1;
            state_nxt    = ST_EMIT;
          end
        end else begin
          grp_nxt = grp_r + 1'b1;
        end
      end
      ST_EMIT: begin
        cmd.rd_step = 1'b1;
        if (sts.rd_zero) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      grp_r   <= '0;
    end else begin
      state_r <= state_nxt;
      grp_r   <= grp_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== design/rita_dp.sv =====
// Datapath for the radix-to-ASCII core: radix register, long division by the
// radix (eight quotient bits a cycle), digit RAM and output stage. Depends on rita_pkg, rita_ram.
module rita_dp #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_DIGITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rita_pkg::dp_cmd_t                 cmd,
  output rita_pkg::dp_sts_t                 sts,
  input  logic [VALUE_BITS-1:0]             in_value,
  input  logic                              cfg_we,
  input  logic [rita_pkg::RADIX_W-1:0]      cfg_radix,
  output logic                              out_strobe,
  output logic [rita_pkg::CHAR_W-1:0]       out_char_code,
  output logic                              out_is_last,
  output logic                              out_is_empty
);
  import rita_pkg::*;

  localparam int DIV_W = ((VALUE_BITS + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
  localparam int AW    = $clog2(MAX_DIGITS);
  localparam int CW    = $clog2(MAX_DIGITS + 1);

  logic [RADIX_W-1:0] radix_r, radix_nxt;
  logic [DIV_W-1:0]   dvd_r, dvd_nxt, dvd_new;
  logic [DIGIT_W-1:0] part_r, part_nxt, part_new;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]      rd_idx_r, rd_idx_nxt;
  logic               p_vld_r, p_vld_nxt;
  logic               p_last_r, p_last_nxt;
  logic               p_empty_r, p_empty_nxt;
  logic [DIGIT_W:0]   trial;
  logic [DIGIT_W:0]   divisor;
  logic [DIGIT_W-1:0] ram_rdata;

  assign divisor = {1'b0, radix_r[DIGIT_W-1:0]};

  // restoring division, MSB first
  always_comb begin
    part_new = part_r;
    dvd_new  = dvd_r;
    trial    = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      trial   = {part_new, dvd_new[DIV_W-1]};
      dvd_new = {dvd_new[DIV_W-2:0], 1'b0};
      if (trial >= divisor) begin
        part_new   = DIGIT_W'(trial - divisor);
        dvd_new[0] = 1'b1;
      end else begin
        part_new = trial[DIGIT_W-1:0];
      end
    end
  end

  assign sts.radix_bad = (radix_r < RADIX_MIN) || (radix_r > RADIX_MAX);
  assign sts.quo_zero  = (dvd_new == '0);
  assign sts.cnt_full  = (cnt_r == CW'(MAX_DIGITS - 1));
  assign sts.rd_zero   = (rd_idx_r == '0);

  always_comb begin
    radix_nxt   = cfg_we ? cfg_radix : radix_r;
    dvd_nxt     = dvd_r;
    part_nxt    = part_r;
    cnt_nxt     = cnt_r;
    rd_idx_nxt  = rd_idx_r;
    p_vld_nxt   = 1'b0;
    p_last_nxt  = p_last_r;
    p_empty_nxt = p_empty_r;
    if (cmd.load) begin
      dvd_nxt  = DIV_W'(in_value);
      part_nxt = '0;
      cnt_nxt  = '0;
    end
    if (cmd.div_step) begin
      dvd_nxt  = dvd_new;
      part_nxt = cmd.div_end ? '0 : part_new;
      if (cmd.div_end) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
    if (cmd.rd_first) begin
      rd_idx_nxt = cnt_r[AW-1:0];
    end
    if (cmd.rd_step) begin
      rd_idx_nxt  = rd_idx_r - 1'b1;
      p_vld_nxt   = 1'b1;
      p_last_nxt  = sts.rd_zero;
      p_empty_nxt = 1'b0;
    end
    if (cmd.empty) begin
      cnt_nxt     = '0;
      dvd_nxt     = '0;
      p_vld_nxt   = 1'b1;
      p_last_nxt  = 1'b1;
      p_empty_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
      p_vld_r <= 1'b0;
      cnt_r   <= '0;
      dvd_r   <= '0;
    end else begin
      radix_r <= radix_nxt;
      p_vld_r <= p_vld_nxt;
      cnt_r   <= cnt_nxt;
      dvd_r   <= dvd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    part_r    <= part_nxt;
    rd_idx_r  <= rd_idx_nxt;
    p_last_r  <= p_last_nxt;
    p_empty_r <= p_empty_nxt;
  end

  rita_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_digits (
    .clk   (clk),
    .we    (cmd.div_end),
    .waddr (cnt_r[AW-1:0]),
    .wdata (part_new),
    .re    (cmd.rd_step),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  assign out_strobe    = p_vld_r;
  assign out_is_last   = p_last_r;
  assign out_is_empty  = p_empty_r;
  assign out_char_code = p_empty_r ? CHAR_NONE : digit_glyph(ram_rdata);

endmodule

// ===== design/rita_chk.sv =====
// Port-level checker for the radix-to-ASCII core, bound to the top level.
// Depends on radix_integer_to_ascii_core_assert.svh and rita_pkg.
`include "radix_integer_to_ascii_core_assert.svh"

module rita_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_strobe,
  input logic [rita_pkg::CHAR_W-1:0] out_char_code,
  input logic                        out_is_last,
  input logic                        out_is_empty
);
  import rita_pkg::*;

  `RITA_ASSERT_IMP(a_empty_form, clk, rst_n, out_strobe && out_is_empty, out_is_last && (out_char_code == CHAR_NONE))
  `RITA_ASSERT_IMP(a_glyph_range, clk, rst_n, out_strobe && !out_is_empty, ((out_char_code >= 7'h30) && (out_char_code <= 7'h39)) || ((out_char_code >= 7'h61) && (out_char_code <= 7'h7a)))
  `RITA_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `RITA_ASSERT_IMP(a_strobe_busy, clk, rst_n, out_strobe, busy)
  `RITA_ASSERT_NXT(a_last_gap, clk, rst_n, out_strobe && out_is_last, !out_strobe)

endmodule

bind radix_integer_to_ascii_core rita_chk u_rita_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_strobe    (out_strobe),
  .out_char_code (out_char_code),
  .out_is_last   (out_is_last),
  .out_is_empty  (out_is_empty)
);

// ===== tb/tb.sv =====
// Testbench for radix_integer_to_ascii_core: directed table, then random values under several radices.
// Expected characters come from the directed text or a local digit-expansion predictor, checked at every out_strobe.
// Depends on rita_pkg and the core RTL only.
module tb;
  import rita_pkg::*;

  localparam int VBITS      = 32;
  localparam int DIGITS_MAX = 32;
  localparam int WATCHDOG   = 5000;
  localparam int TAIL       = 200;
  localparam int PHASES     = 8;
  localparam int PHASE_LEN  = 60;
  localparam int N_DIRECTED = 21;
  localparam logic [CHAR_W-1:0] GLYPH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] GLYPH_ALPHA = 7'h61;

  typedef enum logic [1:0] {CHECK_MODEL, CHECK_TEXT, CHECK_EMPTY} check_kind_t;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
    logic              empty;
  } glyph_t;

  typedef struct {
    logic [RADIX_W-1:0] radix;
    logic [VBITS-1:0]   value;
    check_kind_t        kind;
    string              text;
  } vector_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [VBITS-1:0]    in_value = '0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [RADIX_W-1:0]  cfg_radix = '0;
  logic                out_strobe;
  logic [CHAR_W-1:0]   out_char_code;
  logic                out_is_last;
  logic                out_is_empty;

  glyph_t              glyph_due[$];
  logic [RADIX_W-1:0]  base_radix = RADIX_RESET;
  int                  mismatch_count = 0;
  int                  quiet_cycles = 0;

  vector_t directed_vectors[N_DIRECTED] = '{
    '{8'd10,  32'd0,          CHECK_TEXT,  "0"},
    '{8'd10,  32'd1,          CHECK_TEXT,  "1"},
    '{8'd10,  32'hFFFF_FFFF,  CHECK_TEXT,  "4294967295"},
    '{8'd10,  32'hAAAA_AAAA,  CHECK_MODEL, ""},
    '{8'd2,   32'hFFFF_FFFF,  CHECK_TEXT,  "11111111111111111111111111111111"},
    '{8'd2,   32'h8000_0000,  CHECK_TEXT,  "10000000000000000000000000000000"},
    '{8'd2,   32'd0,          CHECK_TEXT,  "0"},
    '{8'd36,  32'd35,         CHECK_TEXT,  "z"},
    '{8'd36,  32'd36,         CHECK_TEXT,  "10"},
    '{8'd36,  32'hFFFF_FFFF,  CHECK_TEXT,  "1z141z3"},
    '{8'd16,  32'hDEAD_BEEF,  CHECK_TEXT,  "deadbeef"},
    '{8'd16,  32'hFFFF_FFFF,  CHECK_TEXT,  "ffffffff"},
    '{8'd8,   32'hFFFF_FFFF,  CHECK_TEXT,  "37777777777"},
    '{8'd0,   32'd5,          CHECK_EMPTY, ""},
    '{8'd1,   32'd0,          CHECK_EMPTY, ""},
    '{8'd37,  32'd123,        CHECK_EMPTY, ""},
    '{8'd255, 32'hFFFF_FFFF,  CHECK_EMPTY, ""},
    '{8'd3,   32'hFFFF_FFFF,  CHECK_MODEL, ""},
    '{8'd7,   32'h1234_5678,  CHECK_MODEL, ""},
    '{8'd35,  32'h7FFF_FFFF,  CHECK_MODEL, ""},
    '{8'd10,  32'h5555_5555,  CHECK_MODEL, ""}
  };

  radix_integer_to_ascii_core DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_radix     (cfg_radix),
    .out_strobe    (out_strobe),
    .out_char_code (out_char_code),
    .out_is_last   (out_is_last),
    .out_is_empty  (out_is_empty)
  );

  always #1 clk = ~clk;

  // Digit expansion of one value in the current radix, most significant first; an invalid radix gives one empty entry
  function automatic void expand_digits(input logic [VBITS-1:0] v);
    logic [DIGIT_W-1:0] digits[DIGITS_MAX];
    logic [VBITS-1:0]   rest;
    logic [DIGIT_W-1:0] d;
    glyph_t             g;
    int                 n;
    if (base_radix < RADIX_MIN || base_radix > RADIX_MAX) begin
      g.code = '0;
      g.last = 1'b1;
      g.empty = 1'b1;
      glyph_due.push_back(g);
      return;
    end
    rest = v;
    n = 0;
    do begin
      digits[n] = DIGIT_W'(rest % VBITS'(base_radix));
      rest = rest / VBITS'(base_radix);
      n++;
    end while (rest != 0 && n < DIGITS_MAX);
    for (int k = n - 1; k >= 0; k--) begin
      d = (digits[k] > 6'd35) ? 6'd35 : digits[k];
      g.code = (d < 6'd10) ? GLYPH_ZERO + CHAR_W'(d) : GLYPH_ALPHA + CHAR_W'(d - 6'd10);
      g.last = (k == 0);
      g.empty = 1'b0;
      glyph_due.push_back(g);
    end
  endfunction

  function automatic void expect_text(input string text);
    glyph_t g;
    for (int i = 0; i < text.len(); i++) begin
      g.code = CHAR_W'(text[i]);
      g.last = (i == text.len() - 1);
      g.empty = 1'b0;
      glyph_due.push_back(g);
    end
  endfunction

  function automatic logic [VBITS-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return VBITS'($urandom_range(0, 1000));
      5, 6:    return VBITS'($urandom) >> $urandom_range(0, 31);
      default: return VBITS'($urandom);
    endcase
  endfunction

  function automatic logic [RADIX_W-1:0] pick_radix(input int phase);
    int roll;
    roll = $urandom_range(0, 99);
    if (phase == 0) return RADIX_MIN;
    if (phase == 1) return RADIX_MAX;
    if (roll < 70) return RADIX_W'($urandom_range(2, 36));
    if (roll < 85) return RADIX_W'($urandom_range(37, 255));
    return RADIX_W'($urandom_range(0, 1));
  endfunction

  // Register write only once every expected character has arrived
  task automatic set_radix(input logic [RADIX_W-1:0] r);
    while (glyph_due.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_radix <= r;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    base_radix = r;
  endtask

  task automatic send_value(input logic [VBITS-1:0] v, input int idle_pct,
                            input check_kind_t kind, input string text);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (kind)
      CHECK_TEXT:  expect_text(text);
      CHECK_EMPTY: glyph_due.push_back('{code: '0, last: 1'b1, empty: 1'b1});
      default:     expand_digits(v);
    endcase
  endtask

  always @(posedge clk) begin
    glyph_t want;
    if (rst_n && out_strobe) begin
      if (glyph_due.size() == 0) begin
        $display("%0t: unexpected transfer: expected none, actual code %h last %b empty %b",
                 $time, out_char_code, out_is_last, out_is_empty);
        mismatch_count++;
      end else begin
        want = glyph_due.pop_front();
        if (out_char_code !== want.code) begin
          $display("%0t: char_code expected %h actual %h", $time, want.code, out_char_code);
          mismatch_count++;
        end
        if (out_is_last !== want.last) begin
          $display("%0t: is_last expected %b actual %b", $time, want.last, out_is_last);
          mismatch_count++;
        end
        if (out_is_empty !== want.empty) begin
          $display("%0t: is_empty expected %b actual %b", $time, want.empty, out_is_empty);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: cycles with no transfer on any channel
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG) begin
      $display("%0t: watchdog expired, %0d characters outstanding", $time, glyph_due.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int idle_pct;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_vectors[i]) begin
      if (directed_vectors[i].radix != base_radix) begin
        start <= 1'b0;
        set_radix(directed_vectors[i].radix);
      end
      send_value(directed_vectors[i].value, 0, directed_vectors[i].kind,
                 directed_vectors[i].text);
    end
    start <= 1'b0;

    // idle mix per phase: none, sender 61%, receiver only (cannot stall, so none), sender at 36%
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        1:       idle_pct = 61;
        3:       idle_pct = 36;
        default: idle_pct = 0;
      endcase
      set_radix(pick_radix(phase));
      for (int n = 0; n < PHASE_LEN; n++) begin
        send_value(pick_value(), idle_pct, CHECK_MODEL, "");
      end
      start <= 1'b0;
    end

    while (glyph_due.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
